// File: design/rvsd_pkg.sv
// Shared constants, types and codes for the RISC-V subset decoder.
package rvsd_pkg;

  // Address counter.
  localparam int ADDR_WIDTH = 16;                 // counter modulus is 2**ADDR_WIDTH
  localparam int ADDR_OUT_W = 16;                 // fixed width of the address field
  localparam int CNT_W = (ADDR_WIDTH < ADDR_OUT_W) ? ADDR_WIDTH : ADDR_OUT_W;
  localparam logic [CNT_W-1:0] ADDR_STEP = CNT_W'(4);

  // Field widths.
  localparam int WORD_W = 32;
  localparam int MN_W   = 5;
  localparam int REG_W  = 5;
  localparam int IMM_W  = 13;

  // Major opcodes.
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_REG    = 7'b0110011;

  // funct7 values.
  localparam logic [6:0] F7_ZERO = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // funct3 values.
  localparam logic [2:0] F3_ADD = 3'b000;
  localparam logic [2:0] F3_SLL = 3'b001;
  localparam logic [2:0] F3_XOR = 3'b100;
  localparam logic [2:0] F3_SRL = 3'b101;
  localparam logic [2:0] F3_OR  = 3'b110;
  localparam logic [2:0] F3_AND = 3'b111;

  typedef enum logic [MN_W-1:0] {
    MN_LD     = 5'd0,
    MN_SD     = 5'd1,
    MN_BEQ    = 5'd2,
    MN_BNE    = 5'd3,
    MN_ADDI   = 5'd4,
    MN_XORI   = 5'd5,
    MN_ORI    = 5'd6,
    MN_ANDI   = 5'd7,
    MN_SLLI   = 5'd8,
    MN_SRLI   = 5'd9,
    MN_ADD    = 5'd10,
    MN_SUB    = 5'd11,
    MN_XOR    = 5'd12,
    MN_OR     = 5'd13,
    MN_AND    = 5'd14,
    MN_FINISH = 5'd15,
    MN_NONE   = 5'd16
  } mnem_t;

  typedef struct packed {
    logic [ADDR_OUT_W-1:0] address;
    mnem_t                 mnemonic;
    logic [REG_W-1:0]      dest_reg;
    logic [REG_W-1:0]      src1_reg;
    logic [REG_W-1:0]      src2_reg;
    logic [IMM_W-1:0]      imm_magnitude;
    logic                  imm_negative;
  } res_t;

endpackage

// File: design/rvsd_ifs.sv
// Handshake channels: instruction words in, decoded results out.
interface rvsd_in_if;
  import rvsd_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

interface rvsd_out_if;
  import rvsd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [ADDR_OUT_W-1:0] address;
  logic [MN_W-1:0]       mnemonic;
  logic [REG_W-1:0]      dest_reg;
  logic [REG_W-1:0]      src1_reg;
  logic [REG_W-1:0]      src2_reg;
  logic [IMM_W-1:0]      imm_magnitude;
  logic                  imm_negative;

  modport source (output valid, output address, output mnemonic, output dest_reg,
                  output src1_reg, output src2_reg, output imm_magnitude,
                  output imm_negative, input ready);
  modport sink   (input valid, input address, input mnemonic, input dest_reg,
                  input src1_reg, input src2_reg, input imm_magnitude,
                  input imm_negative, output ready);
endinterface

// File: design/riscv_subset_instruction_decoder.sv
// Top level: RISC-V subset decoder, input register, decode, result register.
//
//   channel  dir  handshake            payload
//   in_ch    in   valid / ready        instr_word[31:0]
//   out_ch   out  valid / ready        address, mnemonic, dest_reg, src1_reg,
//                                      src2_reg, imm_magnitude, imm_negative
//
// An accepted input beat passes through the input register and then, after the
// shallow decode, the result register before it leaves as its result beat.
// Throughput is one beat per cycle while out_ch.ready stays high.
// rst_n (synchronous, active low) empties both stages and zeroes the address
// counter. A stalled result holds in the result register; the input register
// keeps taking beats until it too is full, then in_ch.ready drops.
module riscv_subset_instruction_decoder (
  input  logic       clk,
  input  logic       rst_n,
  rvsd_in_if.sink    in_ch,
  rvsd_out_if.source out_ch
);
  import rvsd_pkg::*;

  // Address counter: value is the address of the next accepted word.
  logic [CNT_W-1:0]      addr_cnt_r;
  logic [CNT_W-1:0]      addr_cnt_nxt;

  // Input stage
  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  logic [WORD_W-1:0]     s1_word_r;
  logic [ADDR_OUT_W-1:0] s1_addr_r;

  // Result stage
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  res_t                  out_res_r;
  res_t                  dec_res;

  logic                  in_fire;
  logic                  s1_adv;   // result register free to take the input stage
  logic                  s1_move;  // input stage item moves to the result register

  assign s1_adv  = !out_valid_r || out_ch.ready;
  assign s1_move = s1_valid_r && s1_adv;

  // Input stage takes a beat when empty or emptying this cycle
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Counter wraps at 2**CNT_W, matching the mask on the address field
  assign addr_cnt_nxt = in_fire ? addr_cnt_r + ADDR_STEP : addr_cnt_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_cnt_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      addr_cnt_r  <= addr_cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r <= in_ch.instr_word;
      s1_addr_r <= ADDR_OUT_W'(addr_cnt_r);
    end
    if (s1_move) begin
      out_res_r <= dec_res;
    end
  end

  rvsd_decode u_decode (
    .word (s1_word_r),
    .addr (s1_addr_r),
    .res  (dec_res)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.address       = out_res_r.address;
  assign out_ch.mnemonic      = out_res_r.mnemonic;
  assign out_ch.dest_reg      = out_res_r.dest_reg;
  assign out_ch.src1_reg      = out_res_r.src1_reg;
  assign out_ch.src2_reg      = out_res_r.src2_reg;
  assign out_ch.imm_magnitude = out_res_r.imm_magnitude;
  assign out_ch.imm_negative  = out_res_r.imm_negative;

endmodule

// File: design/rvsd_decode.sv
// Combinational decode of one instruction word into mnemonic, fields and immediate.
module rvsd_decode (
  input  logic [rvsd_pkg::WORD_W-1:0]     word,
  input  logic [rvsd_pkg::ADDR_OUT_W-1:0] addr,
  output rvsd_pkg::res_t                  res
);
  import rvsd_pkg::*;

  logic [6:0]       opcode;
  logic [2:0]       f3;
  logic [6:0]       f7;
  logic [IMM_W-1:0] br_off;
  logic [IMM_W-1:0] br_neg_off;

  assign opcode = word[6:0];
  assign f3     = word[14:12];
  assign f7     = word[31:25];

  // B-type offset, bit 0 always zero
  assign br_off     = {word[31], word[7], word[30:25], word[11:8], 1'b0};
  assign br_neg_off = IMM_W'(~br_off + 1'b1);

  always_comb begin
    res               = '0;
    res.address       = addr;
    res.dest_reg      = word[11:7];
    res.src1_reg      = word[19:15];
    res.src2_reg      = word[24:20];
    res.mnemonic      = MN_FINISH;
    res.imm_magnitude = '0;
    res.imm_negative  = 1'b0;
    case (opcode)
      OP_LOAD: begin
        res.mnemonic      = MN_LD;
        res.imm_magnitude = IMM_W'(word[31:20]);
      end
      OP_STORE: begin
        res.mnemonic      = MN_SD;
        res.imm_magnitude = IMM_W'({f7, word[11:7]});
      end
      OP_BRANCH: begin
        res.mnemonic      = f3[0] ? MN_BNE : MN_BEQ;
        res.imm_negative  = word[31];
        // most negative offset wraps back to 4096, which is the right magnitude
        res.imm_magnitude = word[31] ? br_neg_off : br_off;
      end
      OP_IMM: begin
        res.imm_magnitude = IMM_W'(word[31:20]);
        case (f3)
          F3_ADD:  res.mnemonic = MN_ADDI;
          F3_XOR:  res.mnemonic = MN_XORI;
          F3_OR:   res.mnemonic = MN_ORI;
          F3_AND:  res.mnemonic = MN_ANDI;
          F3_SLL:  res.mnemonic = MN_SLLI;
          F3_SRL:  res.mnemonic = MN_SRLI;  // funct7 not checked
          default: begin
            res.mnemonic      = MN_NONE;
            res.imm_magnitude = '0;
          end
        endcase
      end
      OP_REG: begin
        res.mnemonic = MN_NONE;
        if (f7 == F7_ZERO) begin
          case (f3)
            F3_ADD:  res.mnemonic = MN_ADD;
            F3_XOR:  res.mnemonic = MN_XOR;
            F3_OR:   res.mnemonic = MN_OR;
            F3_AND:  res.mnemonic = MN_AND;
            default: res.mnemonic = MN_NONE;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          res.mnemonic = MN_SUB;
        end
      end
      default: res.mnemonic = MN_FINISH;
    endcase
  end

endmodule
